>>> rtl/cobol_token_classifier_assert.svh
`ifndef COBOL_TOKEN_CLASSIFIER_ASSERT_SVH
`define COBOL_TOKEN_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CTC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ctc_pkg.sv
package ctc_pkg;

    localparam int LINE_BITS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 12;
    localparam int LENGTH_BITS_DEF = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int KW_MAX_LEN  = 14;
    localparam int KW_COUNT    = 4;

    localparam logic [3:0] KIND_IDENT    = 4'd0;
    localparam logic [3:0] KIND_KW_FIRST = 4'd1;
    localparam logic [3:0] KIND_NUMBER   = 4'd5;
    localparam logic [3:0] KIND_LITERAL  = 4'd6;
    localparam logic [3:0] KIND_PERIOD   = 4'd7;
    localparam logic [3:0] KIND_INVALID  = 4'd8;
    localparam logic [3:0] KIND_END      = 4'd9;

    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [7:0] CHAR_PERIOD = 8'h2E;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    function automatic logic [3:0] kw_len(input logic [1:0] k);
        logic [3:0] len;
        case (k)
            2'd0:    len = 4'd14;
            2'd1:    len = 4'd10;
            2'd2:    len = 4'd4;
            default: len = 4'd9;
        endcase
        return len;
    endfunction

    // Keyword text padded with spaces; character i sits in byte KW_MAX_LEN-1-i
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] i);
        logic [8*KW_MAX_LEN-1:0] text;
        logic [3:0]              pos;
        case (k)
            2'd0:    text = "IDENTIFICATION";
            2'd1:    text = "PROGRAM-ID    ";
            2'd2:    text = "DATA          ";
            default: text = "PROCEDURE     ";
        endcase
        pos = 4'(KW_MAX_LEN - 1) - i;
        if (i >= 4'(KW_MAX_LEN))
            return 8'h00;
        return text[8*pos +: 8];
    endfunction

endpackage

>>> rtl/ctc_char_if.sv
interface ctc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_marker;

    modport source (output valid, output char_code, output end_marker, input ready);
    modport sink   (input valid, input char_code, input end_marker, output ready);
endinterface

>>> rtl/ctc_token_if.sv
interface ctc_token_if #(
    parameter int LINE_BITS   = ctc_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = ctc_pkg::COLUMN_BITS_DEF,
    parameter int LENGTH_BITS = ctc_pkg::LENGTH_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [3:0]             token_kind;
    logic [LINE_BITS-1:0]   token_line;
    logic [COLUMN_BITS-1:0] token_column;
    logic [LENGTH_BITS-1:0] token_length;
    logic [7:0]             first_char;
    logic                   last_of_run;

    modport source (
        output valid, output token_kind, output token_line, output token_column,
        output token_length, output first_char, output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input token_line, input token_column,
        input token_length, input first_char, input last_of_run, output ready
    );
endinterface

>>> rtl/cobol_token_classifier.sv
// Channel  Dir  Payload                                          Word accepted when
// chars    in   char_code[7:0], end_marker                        valid && ready
// tokens   out  token_kind[3:0], token_line, token_column,        valid && ready
//               token_length, first_char[7:0], last_of_run
//
// One character is taken per cycle; it is registered, then scanned in one pass
// that updates the lexer state and writes zero, one or two token words to a
// four-word result queue. A token is presented from the queue once the step
// that its closing character drives has written the token's word there.
// Input stalls only while the queue holds more than two words; a character that
// closes two tokens writes two words, which a ready sink takes one after the other.
// Reset (rst_n low, asynchronous) gives line 1, column 0, no open token.
module cobol_token_classifier #(
    parameter int LINE_BITS   = ctc_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = ctc_pkg::COLUMN_BITS_DEF,
    parameter int LENGTH_BITS = ctc_pkg::LENGTH_BITS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    ctc_char_if.sink   chars,
    ctc_token_if.source tokens
);

    localparam int RES_W = 4 + LINE_BITS + COLUMN_BITS + LENGTH_BITS + 8 + 1;

    logic                  room;
    logic [1:0]            push_count;
    logic [1:0][RES_W-1:0] push_word;
    logic [RES_W-1:0]      out_word;

    ctc_scanner #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_scanner (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .room       (room),
        .push_count (push_count),
        .push_word  (push_word)
    );

    ctc_result_fifo #(
        .WIDTH (RES_W)
    ) u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_word  (push_word),
        .room       (room),
        .out_valid  (tokens.valid),
        .out_ready  (tokens.ready),
        .out_word   (out_word)
    );

    assign {tokens.token_kind, tokens.token_line, tokens.token_column,
            tokens.token_length, tokens.first_char, tokens.last_of_run} = out_word;

endmodule

>>> rtl/ctc_scanner.sv
module ctc_scanner #(
    parameter int LINE_BITS   = ctc_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = ctc_pkg::COLUMN_BITS_DEF,
    parameter int LENGTH_BITS = ctc_pkg::LENGTH_BITS_DEF,
    localparam int RES_W      = 4 + LINE_BITS + COLUMN_BITS + LENGTH_BITS + 8 + 1
)(
    input  logic                   clk,
    input  logic                   rst_n,
    ctc_char_if.sink               chars,
    input  logic                   room,
    output logic [1:0]             push_count,
    output logic [1:0][RES_W-1:0]  push_word
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_LIT,
        MODE_LIT_QUOTE
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic                   dquote_reg, dquote_next;
    logic [LINE_BITS-1:0]   cur_line_reg, cur_line_next;
    logic [COLUMN_BITS-1:0] cur_col_reg, cur_col_next;
    logic [LINE_BITS-1:0]   start_line_reg, start_line_next;
    logic [COLUMN_BITS-1:0] start_col_reg, start_col_next;
    logic [LENGTH_BITS-1:0] run_reg, run_next;
    logic [3:0]             cand_reg, cand_next;
    logic [7:0]             start_char_reg, start_char_next;
    logic                   in_vld_reg;
    logic [7:0]             char_reg;
    logic                   end_reg;

    logic                   step;
    logic [7:0]             c;
    logic [7:0]             delim;
    logic [COLUMN_BITS-1:0] col;
    logic [LENGTH_BITS-1:0] run_grown;
    logic [3:0]             close_kind;
    logic                   do_begin;
    logic [1:0]             n;
    logic [1:0][RES_W-1:0]  words;

    function automatic logic [RES_W-1:0] pack(
        input logic [3:0]             kind,
        input logic [LINE_BITS-1:0]   ln,
        input logic [COLUMN_BITS-1:0] cl,
        input logic [LENGTH_BITS-1:0] len,
        input logic [7:0]             ch
    );
        return {kind, ln, cl, len, ch, 1'b0};
    endfunction

    // Drop every keyword that the character at this index rules out
    function automatic logic [3:0] narrow(
        input logic [3:0]             cand,
        input logic [LENGTH_BITS-1:0] idx,
        input logic [7:0]             ch
    );
        logic [7:0] u;
        logic [3:0] res;
        u   = ctc_pkg::to_upper(ch);
        res = cand;
        for (int k = 0; k < ctc_pkg::KW_COUNT; k++) begin
            if (idx >= LENGTH_BITS'(ctc_pkg::kw_len(2'(k)))
                || ctc_pkg::kw_char(2'(k), idx[3:0]) != u)
                res[k] = 1'b0;
        end
        return res;
    endfunction

    assign step        = in_vld_reg && room;
    assign chars.ready = !in_vld_reg || room;
    assign c           = char_reg;
    assign delim       = dquote_reg ? ctc_pkg::CHAR_DQUOTE : ctc_pkg::CHAR_SQUOTE;
    assign col         = (cur_col_reg != '1) ? cur_col_reg + 1'b1 : cur_col_reg;
    assign run_grown   = (run_reg != '1) ? run_reg + 1'b1 : run_reg;

    always_comb
    begin
        close_kind = ctc_pkg::KIND_IDENT;
        if (mode_reg == MODE_NUMBER)
            close_kind = ctc_pkg::KIND_NUMBER;
        else
        begin
            for (int k = 0; k < ctc_pkg::KW_COUNT; k++) begin
                if (cand_reg[k] && run_reg == LENGTH_BITS'(ctc_pkg::kw_len(2'(k))))
                    close_kind = ctc_pkg::KIND_KW_FIRST + 4'(k);
            end
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        dquote_next     = dquote_reg;
        cur_line_next   = cur_line_reg;
        cur_col_next    = cur_col_reg;
        start_line_next = start_line_reg;
        start_col_next  = start_col_reg;
        run_next        = run_reg;
        cand_next       = cand_reg;
        start_char_next = start_char_reg;
        do_begin        = 1'b0;
        n               = 2'd0;
        words           = '0;

        if (step)
        begin
            if (end_reg)
            begin
                case (mode_reg)
                    MODE_IDENT, MODE_NUMBER:
                    begin
                        words[n[0]] = pack(close_kind, start_line_reg, start_col_reg,
                                           run_reg, start_char_reg);
                        n = n + 2'd1;
                    end
                    MODE_LIT:
                    begin
                        words[n[0]] = pack(ctc_pkg::KIND_INVALID, start_line_reg,
                                           start_col_reg, run_reg, start_char_reg);
                        n = n + 2'd1;
                    end
                    MODE_LIT_QUOTE:
                    begin
                        words[n[0]] = pack(ctc_pkg::KIND_LITERAL, start_line_reg,
                                           start_col_reg, run_reg, start_char_reg);
                        n = n + 2'd1;
                    end
                    default: ;
                endcase
                words[n[0]] = pack(ctc_pkg::KIND_END, cur_line_reg, col, '0, 8'h00);
                n = n + 2'd1;
                // Back to the reset state
                mode_next       = MODE_IDLE;
                dquote_next     = 1'b0;
                cur_line_next   = LINE_BITS'(1);
                cur_col_next    = '0;
                start_line_next = LINE_BITS'(1);
                start_col_next  = COLUMN_BITS'(1);
                run_next        = '0;
                cand_next       = '1;
                start_char_next = 8'h00;
            end
            else
            begin
                if (c == ctc_pkg::CHAR_LF)
                begin
                    cur_line_next = (cur_line_reg != '1) ? cur_line_reg + 1'b1 : cur_line_reg;
                    cur_col_next  = '0;
                end
                else
                    cur_col_next = col;

                case (mode_reg)
                    MODE_IDENT:
                    begin
                        if (ctc_pkg::is_letter(c) || ctc_pkg::is_digit(c)
                            || c == ctc_pkg::CHAR_HYPHEN)
                        begin
                            cand_next = narrow(cand_reg, run_reg, c);
                            run_next  = run_grown;
                        end
                        else
                        begin
                            words[n[0]] = pack(close_kind, start_line_reg, start_col_reg,
                                               run_reg, start_char_reg);
                            n = n + 2'd1;
                            mode_next = MODE_IDLE;
                            do_begin  = 1'b1;
                        end
                    end
                    MODE_NUMBER:
                    begin
                        if (ctc_pkg::is_digit(c))
                            run_next = run_grown;
                        else
                        begin
                            words[n[0]] = pack(close_kind, start_line_reg, start_col_reg,
                                               run_reg, start_char_reg);
                            n = n + 2'd1;
                            mode_next = MODE_IDLE;
                            do_begin  = 1'b1;
                        end
                    end
                    MODE_LIT:
                    begin
                        if (c == delim)
                        begin
                            run_next  = run_grown;
                            mode_next = MODE_LIT_QUOTE;
                        end
                        else if (c == ctc_pkg::CHAR_CR || c == ctc_pkg::CHAR_LF)
                        begin
                            words[n[0]] = pack(ctc_pkg::KIND_INVALID, cur_line_reg, col,
                                               LENGTH_BITS'(1), c);
                            n = n + 2'd1;
                            mode_next = MODE_IDLE;
                        end
                        else
                            run_next = run_grown;
                    end
                    MODE_LIT_QUOTE:
                    begin
                        if (c == delim)
                        begin
                            run_next  = run_grown;
                            mode_next = MODE_LIT;
                        end
                        else
                        begin
                            words[n[0]] = pack(ctc_pkg::KIND_LITERAL, start_line_reg,
                                               start_col_reg, run_reg, start_char_reg);
                            n = n + 2'd1;
                            mode_next = MODE_IDLE;
                            do_begin  = 1'b1;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                        do_begin  = 1'b1;
                    end
                endcase

                // Open a new token on this character unless it is whitespace
                if (do_begin && !ctc_pkg::is_space(c))
                begin
                    start_line_next = cur_line_reg;
                    start_col_next  = col;
                    start_char_next = c;
                    run_next        = LENGTH_BITS'(1);
                    if (c == ctc_pkg::CHAR_SQUOTE || c == ctc_pkg::CHAR_DQUOTE)
                    begin
                        mode_next   = MODE_LIT;
                        dquote_next = (c == ctc_pkg::CHAR_DQUOTE);
                    end
                    else if (ctc_pkg::is_letter(c))
                    begin
                        mode_next = MODE_IDENT;
                        cand_next = narrow(4'hF, '0, c);
                    end
                    else if (ctc_pkg::is_digit(c))
                        mode_next = MODE_NUMBER;
                    else
                    begin
                        words[n[0]] = pack((c == ctc_pkg::CHAR_PERIOD) ? ctc_pkg::KIND_PERIOD
                                           : ctc_pkg::KIND_INVALID,
                                           cur_line_reg, col, LENGTH_BITS'(1), c);
                        n = n + 2'd1;
                    end
                end
            end

            // Mark the final word of this step
            if (n == 2'd2)
                words[1][0] = 1'b1;
            else if (n == 2'd1)
                words[0][0] = 1'b1;
        end
    end

    assign push_count = n;
    assign push_word  = words;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            dquote_reg     <= 1'b0;
            cur_line_reg   <= LINE_BITS'(1);
            cur_col_reg    <= '0;
            start_line_reg <= LINE_BITS'(1);
            start_col_reg  <= COLUMN_BITS'(1);
            run_reg        <= '0;
            cand_reg       <= '1;
            start_char_reg <= 8'h00;
            in_vld_reg     <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            dquote_reg     <= dquote_next;
            cur_line_reg   <= cur_line_next;
            cur_col_reg    <= cur_col_next;
            start_line_reg <= start_line_next;
            start_col_reg  <= start_col_next;
            run_reg        <= run_next;
            cand_reg       <= cand_next;
            start_char_reg <= start_char_next;
            if (chars.ready)
                in_vld_reg <= chars.valid;
        end
    end

    // Hold the incoming word until the step takes it
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            char_reg <= chars.char_code;
            end_reg  <= chars.end_marker;
        end
    end

endmodule

>>> rtl/ctc_result_fifo.sv
module ctc_result_fifo #(
    parameter int WIDTH = 8
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            push_count,
    input  logic [1:0][WIDTH-1:0] push_word,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [WIDTH-1:0]      out_word
);

    localparam int DEPTH  = ctc_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = PTR_W + 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign out_valid = count_reg != '0;
    assign out_word  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // Space for the largest burst of one step
    assign room      = count_reg <= CNT_W'(DEPTH - 2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem_reg[wr_ptr_reg] <= push_word[0];
        if (push_count == 2'd2)
            mem_reg[wr_ptr_reg + 1'b1] <= push_word[1];
    end

endmodule

>>> rtl/ctc_checker.sv
`include "cobol_token_classifier_assert.svh"

module ctc_checker #(
    parameter int LINE_BITS   = ctc_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = ctc_pkg::COLUMN_BITS_DEF,
    parameter int LENGTH_BITS = ctc_pkg::LENGTH_BITS_DEF
)(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [3:0]             token_kind,
    input logic [LINE_BITS-1:0]   token_line,
    input logic [COLUMN_BITS-1:0] token_column,
    input logic [LENGTH_BITS-1:0] token_length,
    input logic [7:0]             first_char,
    input logic                   last_of_run
);

    `CTC_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(token_line) && $stable(token_column) && $stable(token_length) && $stable(first_char) && $stable(last_of_run), "token word changed while stalled")

    `CTC_ASSERT_IMPLY(a_end_token, out_valid && token_kind == ctc_pkg::KIND_END, last_of_run && token_length == '0 && first_char == 8'h00, "malformed end token")

    `CTC_ASSERT_IMPLY(a_period_token, out_valid && token_kind == ctc_pkg::KIND_PERIOD, last_of_run && token_length == LENGTH_BITS'(1) && first_char == ctc_pkg::CHAR_PERIOD, "malformed period token")

    `CTC_ASSERT_IMPLY(a_position_nonzero, out_valid, token_line != '0 && token_column != '0, "token position is zero")

endmodule

bind cobol_token_classifier ctc_checker #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .LENGTH_BITS (LENGTH_BITS)
) u_ctc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (tokens.valid),
    .out_ready    (tokens.ready),
    .token_kind   (tokens.token_kind),
    .token_line   (tokens.token_line),
    .token_column (tokens.token_column),
    .token_length (tokens.token_length),
    .first_char   (tokens.first_char),
    .last_of_run  (tokens.last_of_run)
);
